FILE: src/rrsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin switch allocator package
// Shared sizes, the arbitration pointer bundle and the grant bundle.
// ----------------------------------------------------------------------------
package rrsa_pkg;

  localparam int unsigned PORT_COUNT   = 4;
  localparam int unsigned NUM_NETWORKS = 2;
  localparam int unsigned NUM_CHANNELS = 2;

  localparam int unsigned PORT_W = 2;
  localparam int unsigned NET_W  = 1;
  localparam int unsigned CHAN_W = 1;
  localparam int unsigned NUM_REQ = PORT_COUNT * NUM_NETWORKS * NUM_CHANNELS;
  localparam int unsigned REQ_W  = PORT_W + NET_W + CHAN_W;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Rotating start points of the arbitration search.
  typedef struct packed {
    logic [PORT_W-1:0] recv;
    logic [PORT_W-1:0] send;
    logic [NET_W-1:0]  net;
    logic [CHAN_W-1:0] chan;
  } rrsa_ptr_t;

  // Result of one arbitration round.
  typedef struct packed {
    logic [NUM_REQ-1:0]           cleared;
    logic [PORT_COUNT-1:0]        dest_chan;
    logic [PORT_COUNT-1:0]        chan;
    logic [PORT_COUNT-1:0]        net;
    logic [PORT_COUNT*PORT_W-1:0] sender;
    logic [PORT_COUNT-1:0]        valid;
  } rrsa_grant_t;

endpackage

FILE: src/round_robin_switch_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin switch allocator, top level
// Path: an accepted item is held in the input register, and its result is then
// taken into the result register, which drives the output.
// Throughput: one item per cycle while the downstream side takes results, set by
// the single-pass allocation logic between the input and the result register.
// Reset: asynchronous, active low; all ports present, pointers at zero,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
module round_robin_switch_allocator_top
  import rrsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration: port_present_mask, written when cfg_we_i is high.
  input  logic                  cfg_we_i,
  input  logic [PORT_COUNT-1:0] cfg_wdata_i,

  // Input items.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata, lowest bit up: recv_busy[3:0], send_busy[7:4],
  // pending_requests[23:8], request_dest_ports[55:24], dest_channel_map[71:56].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,

  // Result items.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata, lowest bit up: grant_valid[3:0], grant_sender[11:4],
  // grant_network[15:12], grant_channel[19:16], grant_dest_channel[23:20],
  // requests_cleared[39:24].
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // The present mask is a plain configuration register; the user must change it only
  // while the pipeline is empty (not enforced here); allocation reads it directly.
  logic [PORT_COUNT-1:0] present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '1;
    end else if (cfg_we_i) begin
      present_q <= cfg_wdata_i;
    end
  end

  // Input register stage. It accepts a new item whenever it is empty or its
  // current item moves on to the result register in the same cycle.
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                 alloc_fire;

  assign alloc_fire      = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || alloc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // Rotating pointers. Every arbitration round advances each of them by one,
  // wrapping at its count; they step exactly when a round's result is taken
  // into the result register.
  rrsa_ptr_t ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (alloc_fire) begin
      ptr_q.recv <= ptr_q.recv + PORT_W'(1);
      ptr_q.send <= ptr_q.send + PORT_W'(1);
      ptr_q.net  <= ptr_q.net + NET_W'(1);
      ptr_q.chan <= ptr_q.chan + CHAN_W'(1);
    end
  end

  // The allocation itself is a single combinational pass over the registered
  // item.
  rrsa_grant_t grant;

  rrsa_alloc u_alloc (
    .ptr_i           (ptr_q),
    .present_i       (present_q),
    .recv_busy_i     (in_data_q[3:0]),
    .send_busy_i     (in_data_q[7:4]),
    .pending_i       (in_data_q[23:8]),
    .dest_ports_i    (in_data_q[55:24]),
    .dest_chan_map_i (in_data_q[71:56]),
    .grant_o         (grant)
  );

  // Result register. It holds a finished item until the downstream side takes
  // it, while the input register can already hold the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_fire) begin
      out_data_q <= {grant.cleared, grant.dest_chan, grant.chan, grant.net,
                     grant.sender, grant.valid};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: src/rrsa_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin switch allocator core
// One separable arbitration round: receivers in rotating order, each taking
// the first eligible sender, network and channel from the rotating pointers.
// ----------------------------------------------------------------------------
module rrsa_alloc
  import rrsa_pkg::*;
(
  input  rrsa_ptr_t                     ptr_i,
  input  logic [PORT_COUNT-1:0]         present_i,
  input  logic [PORT_COUNT-1:0]         recv_busy_i,
  input  logic [PORT_COUNT-1:0]         send_busy_i,
  input  logic [NUM_REQ-1:0]            pending_i,
  input  logic [NUM_REQ*PORT_W-1:0]     dest_ports_i,
  input  logic [NUM_REQ-1:0]            dest_chan_map_i,
  output rrsa_grant_t                   grant_o
);

  always_comb begin
    logic [PORT_COUNT-1:0] send_free;
    logic                 found;
    logic [PORT_W-1:0]    r;
    logic [PORT_W-1:0]    s;
    logic [NET_W-1:0]     vn;
    logic [CHAN_W-1:0]    vc;
    logic [REQ_W-1:0]     idx;
    logic [PORT_W-1:0]    s_sel;
    logic [REQ_W-1:0]     idx_sel;
    logic [NET_W-1:0]     vn_sel;
    logic [CHAN_W-1:0]    vc_sel;

    grant_o   = '0;
    send_free = present_i & ~send_busy_i;
    r = '0; s = '0; vn = '0; vc = '0; idx = '0;
    s_sel = '0; idx_sel = '0; vn_sel = '0; vc_sel = '0;

    for (int i = 0; i < PORT_COUNT; i++) begin
      r     = PORT_W'(ptr_i.recv + PORT_W'(i));
      found = 1'b0;
      if (present_i[r] && !recv_busy_i[r]) begin
        for (int j = 0; j < PORT_COUNT; j++) begin
          s = PORT_W'(ptr_i.send + PORT_W'(j));
          if (!found && (s != r) && send_free[s]) begin
            for (int a = 0; a < NUM_NETWORKS; a++) begin
              vn = NET_W'(ptr_i.net + NET_W'(a));
              for (int b = 0; b < NUM_CHANNELS; b++) begin
                vc  = CHAN_W'(ptr_i.chan + CHAN_W'(b));
                idx = {s, vn, vc};
                if (!found && pending_i[idx] &&
                    (dest_ports_i[{idx, 1'b0} +: PORT_W] == r)) begin
                  found   = 1'b1;
                  s_sel   = s;
                  idx_sel = idx;
                  vn_sel  = vn;
                  vc_sel  = vc;
                end
              end
            end
          end
        end
      end
      if (found) begin
        send_free[s_sel]                  = 1'b0;
        grant_o.valid[r]                  = 1'b1;
        grant_o.sender[{r, 1'b0} +: PORT_W] = s_sel;
        grant_o.net[r]                    = vn_sel[0];
        grant_o.chan[r]                   = vc_sel[0];
        grant_o.dest_chan[r]              = dest_chan_map_i[idx_sel];
        grant_o.cleared[idx_sel]          = 1'b1;
      end
    end
  end

endmodule
